>>> hdl/mbe_pkg.sv
// ============================================================================
// mbe_pkg
// Shared widths, constants, state encoding and control structs for the
// Mandelbrot escape-time block.
// ============================================================================
package mbe_pkg;

    // Field widths
    localparam int C_W      = 32;   // input coordinate, Q4.28
    localparam int IN_FRAC  = 28;   // fraction bits of the input coordinate
    localparam int ITER_W   = 16;   // iteration limit and counter
    localparam int COLOR_W  = 8;    // result color

    // Constants
    localparam logic [ITER_W-1:0]  MAX_ITER_RESET = 16'd10000;
    localparam logic [COLOR_W-1:0] COLOR_INSIDE   = 8'd255;
    localparam logic [COLOR_W-1:0] COLOR_WRAP     = 8'd254;  // last value before mod wrap

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_UPD,
        ST_DONE
    } mbe_state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;     // capture c, clear z and counters
        logic mul_en;   // register the squares and cross product
        logic step;     // write back the new z, advance counters
        logic finish;   // move the color into the output register
    } mbe_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic at_limit; // iteration count reached max_iter
        logic big;      // |x| or |y| at least 2
        logic escape;   // x^2 + y^2 at least 4
        logic out_full; // output register busy and not taken this cycle
    } mbe_status_t;

endpackage

>>> hdl/mbe_point_if.sv
// ============================================================================
// mbe_point_if
// Request channel carrying one complex point c.
// ============================================================================
interface mbe_point_if import mbe_pkg::*; ();

    logic                  valid;
    logic                  ready;
    logic signed [C_W-1:0] c_real;
    logic signed [C_W-1:0] c_imag;

    modport source (output valid, output c_real, output c_imag, input ready);
    modport sink   (input valid, input c_real, input c_imag, output ready);

endinterface

>>> hdl/mbe_color_if.sv
// ============================================================================
// mbe_color_if
// Request channel carrying one escape-time color.
// ============================================================================
interface mbe_color_if import mbe_pkg::*; ();

    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] color;

    modport source (output valid, output color, input ready);
    modport sink   (input valid, input color, output ready);

endinterface

>>> hdl/mbe_mul.sv
// ============================================================================
// mbe_mul
// Registered unsigned multiplier. Operands wider than 32 bits are split into
// partial products that are registered and summed on the read side.
// ============================================================================
module mbe_mul import mbe_pkg::*; #(
    parameter int OPW = 29
) (
    input  logic             clk,
    input  logic             en,
    input  logic [OPW-1:0]   a,
    input  logic [OPW-1:0]   b,
    output logic [2*OPW-1:0] p
);

    localparam int PW = 2 * OPW;

    generate
        if (OPW <= 32) begin : g_single
            logic [PW-1:0] p_reg;

            // Register the full product
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    p_reg <= a * b;
                end
            end

            assign p = p_reg;
        end
        else begin : g_split
            localparam int HW = OPW - 32;

            logic [63:0]      ll_reg;
            logic [32+HW-1:0] lh_reg;
            logic [32+HW-1:0] hl_reg;
            logic [2*HW-1:0]  hh_reg;

            // Register the four partial products
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    ll_reg <= a[31:0] * b[31:0];
                    lh_reg <= a[31:0] * b[OPW-1:32];
                    hl_reg <= a[OPW-1:32] * b[31:0];
                    hh_reg <= a[OPW-1:32] * b[OPW-1:32];
                end
            end

            // Combine the partial products
            assign p = PW'(ll_reg) + (PW'(lh_reg) << 32) + (PW'(hl_reg) << 32)
                     + (PW'(hh_reg) << 64);
        end
    endgenerate

endmodule

>>> hdl/mbe_dp.sv
// ============================================================================
// mbe_dp
// Datapath: holds c and z, the iteration counters, the limit register and the
// output register; forms squares, escape test and the next z.
// ============================================================================
module mbe_dp import mbe_pkg::*; #(
    parameter int FRAC_BITS = 28
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  mbe_cmd_t              cmd,
    output mbe_status_t           status,
    input  logic signed [C_W-1:0] in_c_real,
    input  logic signed [C_W-1:0] in_c_imag,
    input  logic                  cfg_wr_en,
    input  logic [ITER_W-1:0]     cfg_wr_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [COLOR_W-1:0]    out_color
);

    // z stays below 16 in magnitude; squares are taken only below 2
    localparam int XW  = FRAC_BITS + 5;
    localparam int OPW = FRAC_BITS + 1;
    localparam int PW  = 2 * OPW;
    localparam int SW  = FRAC_BITS + 3;
    localparam logic [XW-1:0] TWO  = {3'b000, 2'b10, {FRAC_BITS{1'b0}}};
    localparam logic [SW-1:0] FOUR = {1'b1, {(SW-1){1'b0}}};

    logic signed [XW-1:0] x_reg, y_reg, cr_reg, ci_reg;
    logic signed [XW-1:0] cr_load, ci_load;
    logic [ITER_W-1:0]    i_reg;
    logic [COLOR_W-1:0]   m_reg;
    logic [ITER_W-1:0]    max_iter_reg;
    logic                 out_valid_reg;
    logic [COLOR_W-1:0]   color_reg;

    logic [XW-1:0]        mx, my;
    logic [PW-1:0]        pxx, pyy, pxy;
    logic [FRAC_BITS+1:0] x2, y2;
    logic [SW-1:0]        xy, sq_sum;
    logic signed [XW-1:0] xy_s, x_new, y_new;
    logic                 neg_xy;

    // Convert c from Q4.28 to the internal format
    generate
        if (FRAC_BITS >= IN_FRAC) begin : g_shl
            assign cr_load = XW'(in_c_real) <<< (FRAC_BITS - IN_FRAC);
            assign ci_load = XW'(in_c_imag) <<< (FRAC_BITS - IN_FRAC);
        end
        else begin : g_shr
            assign cr_load = XW'(in_c_real >>> (IN_FRAC - FRAC_BITS));
            assign ci_load = XW'(in_c_imag >>> (IN_FRAC - FRAC_BITS));
        end
    endgenerate

    // Magnitudes of z
    assign mx = x_reg[XW-1] ? $unsigned(-x_reg) : $unsigned(x_reg);
    assign my = y_reg[XW-1] ? $unsigned(-y_reg) : $unsigned(y_reg);

    mbe_mul #(.OPW(OPW)) u_mul_xx (
        .clk (clk), .en (cmd.mul_en), .a (mx[OPW-1:0]), .b (mx[OPW-1:0]), .p (pxx)
    );
    mbe_mul #(.OPW(OPW)) u_mul_yy (
        .clk (clk), .en (cmd.mul_en), .a (my[OPW-1:0]), .b (my[OPW-1:0]), .p (pyy)
    );
    mbe_mul #(.OPW(OPW)) u_mul_xy (
        .clk (clk), .en (cmd.mul_en), .a (mx[OPW-1:0]), .b (my[OPW-1:0]), .p (pxy)
    );

    // Scale products back, test escape, form next z
    assign x2     = pxx[FRAC_BITS +: FRAC_BITS+2];
    assign y2     = pyy[FRAC_BITS +: FRAC_BITS+2];
    assign xy     = pxy[FRAC_BITS-1 +: SW];
    assign sq_sum = SW'(x2) + SW'(y2);
    assign neg_xy = x_reg[XW-1] ^ y_reg[XW-1];
    assign xy_s   = neg_xy ? -$signed(XW'(xy)) : $signed(XW'(xy));
    assign x_new  = $signed(XW'(x2)) - $signed(XW'(y2)) + cr_reg;
    assign y_new  = xy_s + ci_reg;

    // Status back to the controller
    assign status.at_limit = (i_reg == max_iter_reg);
    assign status.big      = (mx >= TWO) || (my >= TWO);
    assign status.escape   = (sq_sum >= FOUR);
    assign status.out_full = out_valid_reg && !out_ready;

    // Point and iteration registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cr_reg <= cr_load;
            ci_reg <= ci_load;
            x_reg  <= '0;
            y_reg  <= '0;
            i_reg  <= '0;
            m_reg  <= '0;
        end
        else if (cmd.step)
        begin
            x_reg <= x_new;
            y_reg <= y_new;
            i_reg <= i_reg + 1'b1;
            m_reg <= (m_reg == COLOR_WRAP) ? '0 : m_reg + 1'b1;
        end
    end

    // Iteration limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_iter_reg <= MAX_ITER_RESET;
        end
        else if (cfg_wr_en)
        begin
            max_iter_reg <= cfg_wr_data;
        end
    end

    // Output register: load on finish, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            color_reg <= status.at_limit ? COLOR_INSIDE : m_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_color = color_reg;

    // A pending result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> !(out_valid_reg && !out_ready))
        else $error("result overwritten before it was taken");

    // Each update advances the pass count by one
    a_step_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |=> i_reg == ITER_W'($past(i_reg) + 1'b1))
        else $error("pass counter did not advance on update");

endmodule

>>> hdl/mbe_ctrl.sv
// ============================================================================
// mbe_ctrl
// Controller: sequences load, multiply and update passes per point and hands
// the result to the output register.
// ============================================================================
module mbe_ctrl import mbe_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  mbe_status_t status,
    output mbe_cmd_t    cmd
);

    mbe_state_t state_reg, state_next;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (status.at_limit || status.big)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.mul_en = 1'b1;
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                if (status.escape)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.step   = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_DONE:
            begin
                if (!status.out_full)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // A load always starts a pass
    a_load_to_mul: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == ST_MUL)
        else $error("load not followed by a multiply pass");

    // An update pass always follows a multiply pass
    a_upd_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_UPD |-> $past(state_reg) == ST_MUL)
        else $error("update pass without products");

endmodule

>>> hdl/mandelbrot_escape_time.sv
// ============================================================================
// mandelbrot_escape_time
// Mandelbrot escape-time engine: one point c in, one 8-bit color out.
// ============================================================================
// Usage:
//   point  : request channel with c_real and c_imag, signed Q4.28.
//   result : request channel with color, the escape pass mod 255, or 255
//            when max_iter passes run without escape.
//   cfg_wr_en / cfg_wr_data : write max_iter (reset value 10000); write it
//            only while no point is in flight.
// One point is worked at a time. Each pass goes through the three
// registered multipliers and then through the escape test and the z
// update. A point stops on the limit or on large z before a multiply, or
// when it fails the squares test after one. point.ready is high only while
// the engine is idle, from the cycle after a color is registered; that
// color sits in an output register, so the next point is accepted while
// it waits. If the receiver stalls and the output register is still full,
// the engine holds its finished color until the register frees. Reset
// clears the controller, empties the output register and restores
// max_iter to 10000.
// ============================================================================
module mandelbrot_escape_time import mbe_pkg::*; #(
    parameter int FRAC_BITS = 28
) (
    input  logic              clk,
    input  logic              rst_n,
    mbe_point_if.sink         point,
    mbe_color_if.source       result,
    input  logic              cfg_wr_en,
    input  logic [ITER_W-1:0] cfg_wr_data
);

    mbe_cmd_t    cmd;
    mbe_status_t status;
    logic        in_ready;
    logic        out_valid;
    logic [COLOR_W-1:0] out_color;

    mbe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (point.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    mbe_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .in_c_real   (point.c_real),
        .in_c_imag   (point.c_imag),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .out_valid   (out_valid),
        .out_ready   (result.ready),
        .out_color   (out_color)
    );

    // Drive the channel ports
    assign point.ready  = in_ready;
    assign result.valid = out_valid;
    assign result.color = out_color;

endmodule
